@@ rtl/mvn_pkg.sv @@
// Package for the multi-octave value noise block.
// Holds command and register codes, back-end state type and fixed constants.
// No dependencies.
`default_nettype none

package mvn_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
    localparam logic [1:0] REG_OCTAVE_BIAS  = 2'd1;

    localparam logic [3:0]  OCTAVE_COUNT_RESET = 4'd8;
    localparam logic [15:0] OCTAVE_BIAS_RESET  = 16'd8192;
    localparam logic [15:0] BIAS_MIN           = 16'd1024;

    localparam int WEIGHT_FRAC = 28;
    localparam int BIAS_FRAC   = 12;
    localparam int MUL_SPLIT   = 24;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ,
        B_TOP,
        B_BOT,
        B_INTERP,
        B_ROUND,
        B_MUL_LO,
        B_MUL_HI,
        B_NEXT,
        B_WDIV,
        B_FDIV,
        B_OUT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/mvn_front.sv @@
// Front end: accepts input transfers, classifies them and queues them.
// Uses mvn_pkg.
`default_nettype none

module mvn_front #(
    parameter int GRID_SIZE = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               cmd,
    input  wire logic [7:0]                         pos_x,
    input  wire logic [7:0]                         pos_y,
    input  wire logic [15:0]                        seed_value,
    output logic                                    q_valid,
    output logic                                    q_query,
    output logic [$clog2(GRID_SIZE)-1:0]            q_x,
    output logic [$clog2(GRID_SIZE)-1:0]            q_y,
    output logic [15:0]                             q_seed,
    input  wire logic                               q_pop
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int EW    = 1 + 2 * CW + 16;
    localparam int DEPTH = 4;
    localparam int PTRW  = $clog2(DEPTH);

    logic [EW-1:0]   entry_reg [DEPTH];
    logic [PTRW-1:0] wptr_reg, wptr_next;
    logic [PTRW-1:0] rptr_reg, rptr_next;
    logic [PTRW:0]   fill_reg, fill_next;
    logic            push;
    logic [EW-1:0]   head;

    assign in_stall = (fill_reg == (PTRW+1)'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign head     = entry_reg[rptr_reg];
    assign q_query  = (head[EW-1] == mvn_pkg::CMD_QUERY);
    assign q_x      = head[EW-2 -: CW];
    assign q_y      = head[EW-2-CW -: CW];
    assign q_seed   = head[15:0];

    always_comb
    begin
        wptr_next = push ? wptr_reg + PTRW'(1) : wptr_reg;
        rptr_next = q_pop ? rptr_reg + PTRW'(1) : rptr_reg;
        fill_next = fill_reg + (PTRW+1)'(push) - (PTRW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= {cmd, CW'(pos_x), CW'(pos_y), seed_value};
        end
    end

endmodule

`default_nettype wire

@@ rtl/mvn_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none

module mvn_div #(
    parameter int NW = 62,
    parameter int DW = 46
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quot
);

    localparam int CNW = $clog2(NW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign done    = done_reg;
    assign quot    = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg + CNW'(1);
            if (cnt_reg == CNW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

`default_nettype wire

@@ rtl/mvn_back.sv @@
// Back end: seed store, octave sequencer, interpolation and normalisation.
// Uses mvn_pkg and mvn_div.
`default_nettype none

module mvn_back #(
    parameter int GRID_SIZE = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire logic                          q_query,
    input  wire logic [$clog2(GRID_SIZE)-1:0]  q_x,
    input  wire logic [$clog2(GRID_SIZE)-1:0]  q_y,
    input  wire logic [15:0]                   q_seed,
    output logic                               q_pop,
    input  wire logic [3:0]                    octave_count,
    input  wire logic [15:0]                   octave_bias,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [15:0]                        noise_value
);

    localparam int CW     = $clog2(GRID_SIZE);
    localparam int PW     = CW + 1;
    localparam int SW     = $clog2(CW + 1);
    localparam int OW     = $clog2(CW + 2);
    localparam int AD     = 2 * CW;
    localparam int WW     = 29 + 2 * CW;
    localparam int DW     = WW + 1;
    localparam int AW     = WW + 17;
    localparam int TW     = 16 + PW;
    localparam int VW     = 16 + 2 * PW;
    localparam int HW     = WW - mvn_pkg::MUL_SPLIT;
    localparam int MAXOCT = CW + 1;

    mvn_pkg::back_state_t state_reg, state_next;

    logic [15:0]   mem [GRID_SIZE*GRID_SIZE];
    logic [15:0]   rdata_reg;
    logic [AD-1:0] raddr;
    logic          mem_we;

    logic [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [OW-1:0] oct_reg, oct_next, lim_reg, lim_next;
    logic [15:0]   bias_reg, bias_next;
    logic [2:0]    rd_reg, rd_next;
    logic [15:0]   corner_reg [4];
    logic [TW-1:0] top_reg, top_next, bot_reg, bot_next;
    logic [VW-1:0] v_reg, v_next;
    logic [15:0]   samp_reg, samp_next;
    logic [WW-1:0] w_reg, w_next;
    logic [DW-1:0] wsum_reg, wsum_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic          out_valid_reg, out_valid_next;
    logic [15:0]   noise_reg, noise_next;

    logic [SW-1:0] shift;
    logic [PW-1:0] pitch;
    logic [CW-1:0] mask, x1, x2, y1, y2, bx, by;
    logic [PW-1:0] wx0, wx1, wy0, wy1;
    logic [VW-1:0] half;
    logic [4:0]    cnt_ext;
    logic [OW-1:0] lim_clamp;
    logic [39:0]   prod_lo;
    logic [HW+15:0] prod_hi;
    logic          out_free;
    logic          more_oct;

    logic          div_start, div_done;
    logic [AW-1:0] div_num, div_quot;
    logic [DW-1:0] div_den;

    mvn_div #(
        .NW (AW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign shift   = SW'(CW) - SW'(oct_reg);
    assign pitch   = PW'(1) << shift;
    assign mask    = CW'(pitch - PW'(1));
    assign x1      = x_reg & ~mask;
    assign y1      = y_reg & ~mask;
    assign x2      = x1 + CW'(pitch);
    assign y2      = y1 + CW'(pitch);
    assign bx      = x_reg & mask;
    assign by      = y_reg & mask;
    assign wx1     = PW'(bx);
    assign wy1     = PW'(by);
    assign wx0     = pitch - wx1;
    assign wy0     = pitch - wy1;
    assign half    = (VW'(1) << {shift, 1'b0}) >> 1;
    assign prod_lo = samp_reg * w_reg[mvn_pkg::MUL_SPLIT-1:0];
    assign prod_hi = samp_reg * w_reg[WW-1:mvn_pkg::MUL_SPLIT];
    assign out_free = !out_valid_reg || !out_stall;
    assign more_oct = ((OW+1)'(oct_reg) + (OW+1)'(1)) < (OW+1)'(lim_reg);

    assign cnt_ext   = {1'b0, octave_count};
    assign lim_clamp = (cnt_ext == 5'd0) ? OW'(1) :
                       (cnt_ext > 5'(MAXOCT)) ? OW'(MAXOCT) : OW'(octave_count);

    assign q_pop  = (state_reg == mvn_pkg::B_IDLE) && q_valid;
    assign mem_we = q_pop && !q_query;

    always_comb
    begin
        case (rd_reg[1:0])
            2'd0:    raddr = {y1, x1};
            2'd1:    raddr = {y1, x2};
            2'd2:    raddr = {y2, x1};
            default: raddr = {y2, x2};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[{q_y, q_x}] <= q_seed;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvn_pkg::B_IDLE:   if (q_pop && q_query) state_next = mvn_pkg::B_READ;
            mvn_pkg::B_READ:   if (rd_reg == 3'd4) state_next = mvn_pkg::B_TOP;
            mvn_pkg::B_TOP:    state_next = mvn_pkg::B_BOT;
            mvn_pkg::B_BOT:    state_next = mvn_pkg::B_INTERP;
            mvn_pkg::B_INTERP: state_next = mvn_pkg::B_ROUND;
            mvn_pkg::B_ROUND:  state_next = mvn_pkg::B_MUL_LO;
            mvn_pkg::B_MUL_LO: state_next = mvn_pkg::B_MUL_HI;
            mvn_pkg::B_MUL_HI: state_next = mvn_pkg::B_NEXT;
            mvn_pkg::B_NEXT:   state_next = more_oct ? mvn_pkg::B_WDIV : mvn_pkg::B_FDIV;
            mvn_pkg::B_WDIV:   if (div_done) state_next = mvn_pkg::B_READ;
            mvn_pkg::B_FDIV:   if (div_done) state_next = mvn_pkg::B_OUT;
            mvn_pkg::B_OUT:    if (out_free) state_next = mvn_pkg::B_IDLE;
            default:           state_next = mvn_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        oct_next       = oct_reg;
        lim_next       = lim_reg;
        bias_next      = bias_reg;
        rd_next        = rd_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        v_next         = v_reg;
        samp_next      = samp_reg;
        w_next         = w_reg;
        wsum_next      = wsum_reg;
        acc_next       = acc_reg;
        noise_next     = noise_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_start      = 1'b0;
        div_num        = acc_reg + AW'(wsum_reg >> 1);
        div_den        = wsum_reg;
        case (state_reg)
            mvn_pkg::B_IDLE:
            begin
                x_next    = q_x;
                y_next    = q_y;
                oct_next  = '0;
                lim_next  = lim_clamp;
                bias_next = (octave_bias < mvn_pkg::BIAS_MIN) ? mvn_pkg::BIAS_MIN : octave_bias;
                rd_next   = '0;
                w_next    = WW'(1) << mvn_pkg::WEIGHT_FRAC;
                wsum_next = '0;
                acc_next  = '0;
            end
            mvn_pkg::B_READ:
            begin
                rd_next = (rd_reg == 3'd4) ? 3'd0 : rd_reg + 3'd1;
            end
            mvn_pkg::B_TOP:
            begin
                top_next = TW'(wx0) * TW'(corner_reg[0]) + TW'(wx1) * TW'(corner_reg[1]);
            end
            mvn_pkg::B_BOT:
            begin
                bot_next = TW'(wx0) * TW'(corner_reg[2]) + TW'(wx1) * TW'(corner_reg[3]);
            end
            mvn_pkg::B_INTERP:
            begin
                v_next = VW'(wy0) * VW'(top_reg) + VW'(wy1) * VW'(bot_reg);
            end
            mvn_pkg::B_ROUND:
            begin
                samp_next = 16'((v_reg + half) >> {shift, 1'b0});
            end
            mvn_pkg::B_MUL_LO:
            begin
                acc_next  = acc_reg + AW'(prod_lo);
                wsum_next = wsum_reg + DW'(w_reg);
            end
            mvn_pkg::B_MUL_HI:
            begin
                acc_next = acc_reg + (AW'(prod_hi) << mvn_pkg::MUL_SPLIT);
            end
            mvn_pkg::B_NEXT:
            begin
                div_start = 1'b1;
                if (more_oct)
                begin
                    div_num = (AW'(w_reg) << mvn_pkg::BIAS_FRAC) + AW'(bias_reg >> 1);
                    div_den = DW'(bias_reg);
                end
            end
            mvn_pkg::B_WDIV:
            begin
                if (div_done)
                begin
                    w_next   = div_quot[WW-1:0];
                    oct_next = oct_reg + OW'(1);
                end
            end
            mvn_pkg::B_FDIV:
            begin
                if (div_done)
                begin
                    samp_next = (div_quot > AW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
                end
            end
            mvn_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    noise_next     = samp_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                rd_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvn_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            rd_reg        <= '0;
            oct_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_reg        <= rd_next;
            oct_reg       <= oct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        lim_reg   <= lim_next;
        bias_reg  <= bias_next;
        top_reg   <= top_next;
        bot_reg   <= bot_next;
        v_reg     <= v_next;
        samp_reg  <= samp_next;
        w_reg     <= w_next;
        wsum_reg  <= wsum_next;
        acc_reg   <= acc_next;
        noise_reg <= noise_next;
        if (state_reg == mvn_pkg::B_READ && rd_reg != 3'd0)
        begin
            corner_reg[2'(rd_reg - 3'd1)] <= rdata_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

endmodule

`default_nettype wire

@@ rtl/multi_octave_value_noise.sv @@
// A seed write is stored in the seed store when it leaves the queue; a query
// steps through the octaves using the one-bit-per-cycle divider, once for each
// octave weight after the first and once to normalise. Throughput: one query
// at a time in the back end; four-entry input queue. Reset: asynchronous,
// clears control state and loads register defaults; the seed store is not
// cleared.
`default_nettype none

module multi_octave_value_noise #(
    parameter int GRID_SIZE = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [7:0]  pos_x,
    input  wire logic [7:0]  pos_y,
    input  wire logic [15:0] seed_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      noise_value
);

    localparam int CW = $clog2(GRID_SIZE);

    logic [3:0]    octave_count_reg;
    logic [15:0]   octave_bias_reg;
    logic          q_valid, q_query, q_pop;
    logic [CW-1:0] q_x, q_y;
    logic [15:0]   q_seed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= mvn_pkg::OCTAVE_COUNT_RESET;
            octave_bias_reg  <= mvn_pkg::OCTAVE_BIAS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mvn_pkg::REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[3:0];
                mvn_pkg::REG_OCTAVE_BIAS:  octave_bias_reg  <= cfg_data;
                default:                   octave_count_reg <= octave_count_reg;
            endcase
        end
    end

    mvn_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .seed_value (seed_value),
        .q_valid    (q_valid),
        .q_query    (q_query),
        .q_x        (q_x),
        .q_y        (q_y),
        .q_seed     (q_seed),
        .q_pop      (q_pop)
    );

    mvn_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_query      (q_query),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_seed       (q_seed),
        .q_pop        (q_pop),
        .octave_count (octave_count_reg),
        .octave_bias  (octave_bias_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .noise_value  (noise_value)
    );

endmodule

`default_nettype wire

@@ rtl/mvn_checker.sv @@
// Port-level checks for multi_octave_value_noise, bound to the top level.
// No dependencies beyond the top level's ports.
`default_nettype none

module mvn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] noise_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(noise_value))
        else $error("stalled result changed or vanished");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("outputs active during reset");

    a_full_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("queue filled without an input transfer");

endmodule

bind multi_octave_value_noise mvn_checker u_mvn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value)
);

`default_nettype wire

@@ verif/tb_multi_octave_value_noise.sv @@
// Testbench for multi_octave_value_noise: seed writes and noise queries against a
// local predictor of the octave sum, with random idling on both channels.
// Depends on rtl/mvn_pkg.sv and rtl/multi_octave_value_noise.sv.
`default_nettype none

module tb_multi_octave_value_noise;

    localparam int GRID        = 256;
    localparam int MAX_OCTAVES = $clog2(GRID) + 1;
    localparam int SETTLE      = 1000;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = mvn_pkg::CMD_WRITE;
    logic [7:0]  pos_x = '0;
    logic [7:0]  pos_y = '0;
    logic [15:0] seed_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] noise_value;

    multi_octave_value_noise #(.GRID_SIZE(GRID)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .seed_value (seed_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .noise_value(noise_value)
    );

    logic [15:0] seed_mem [0:GRID*GRID-1];
    bit          seed_written [0:GRID*GRID-1];
    logic [3:0]  octave_count_q = mvn_pkg::OCTAVE_COUNT_RESET;
    logic [15:0] octave_bias_q  = mvn_pkg::OCTAVE_BIAS_RESET;
    logic [15:0] noise_expected [$];

    int     mismatches = 0;
    int     writes_sent = 0;
    int     queries_sent = 0;
    int     results_seen = 0;
    int     cfg_writes = 0;
    bit     tx_idle = 1'b1;
    bit     rx_idle = 1'b1;
    int     rx_gap = 0;
    int     rx_hold_left = 0;
    longint cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, noise_expected.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: check each transfer, then draw the stall for the next one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (noise_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %0d", noise_value);
            end
            else
            begin
                if (noise_value !== noise_expected[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_value mismatch: expected %0d, got %0d",
                                 noise_expected[0], noise_value);
                end
                void'(noise_expected.pop_front());
            end
            rx_gap = rx_idle ? $urandom_range(0, 7) : 0;
        end
        else if (rx_gap > 0)
            rx_gap--;
        if (rx_hold_left > 0)
            rx_hold_left--;
        out_stall <= (rx_gap > 0) || (rx_hold_left > 0);
    end

    function automatic longint unsigned corner(input int col, input int row);
        return longint'(seed_mem[row * GRID + col]);
    endfunction

    function automatic logic [15:0] predict_noise(input int px, input int py);
        longint unsigned wt, acc, wsum, bias, pp, top, bot, bx, by, p, r;
        int cnt, x1, y1, x2, y2;
        cnt = octave_count_q;
        if (cnt == 0)
            cnt = 1;
        if (cnt > MAX_OCTAVES)
            cnt = MAX_OCTAVES;
        bias = (octave_bias_q < mvn_pkg::BIAS_MIN) ? mvn_pkg::BIAS_MIN : octave_bias_q;
        wt = 64'd1 << mvn_pkg::WEIGHT_FRAC;
        acc = 0;
        wsum = 0;
        for (int o = 0; o < cnt; o++)
        begin
            p  = GRID >> o;
            x1 = (px / p) * p;
            y1 = (py / p) * p;
            x2 = (x1 + p) % GRID;
            y2 = (y1 + p) % GRID;
            bx = px - x1;
            by = py - y1;
            top = (p - bx) * corner(x1, y1) + bx * corner(x2, y1);
            bot = (p - bx) * corner(x1, y2) + bx * corner(x2, y2);
            pp = p * p;
            acc += (((p - by) * top + by * bot + pp / 2) / pp) * wt;
            wsum += wt;
            wt = (wt * (64'd1 << mvn_pkg::BIAS_FRAC) + bias / 2) / bias;
        end
        r = (acc + wsum / 2) / wsum;
        if (r > 65535)
            r = 65535;
        return r[15:0];
    endfunction

    // one input transfer; valid stays high on return
    task automatic send_item(input logic c, input int px, input int py, input int sv);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        pos_x      <= px[7:0];
        pos_y      <= py[7:0];
        seed_value <= sv[15:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == mvn_pkg::CMD_WRITE)
        begin
            seed_mem[py * GRID + px] = sv[15:0];
            seed_written[py * GRID + px] = 1'b1;
            writes_sent++;
        end
        else
        begin
            noise_expected.push_back(predict_noise(px, py));
            queries_sent++;
        end
    endtask

    function automatic int draw_seed();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // seed every corner any octave of this point may read, then query it
    task automatic query_point(input int px, input int py);
        int p, x1, y1, xs[2], ys[2];
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            p = GRID >> o;
            x1 = (px / p) * p;
            y1 = (py / p) * p;
            xs[0] = x1;
            xs[1] = (x1 + p) % GRID;
            ys[0] = y1;
            ys[1] = (y1 + p) % GRID;
            foreach (xs[i])
                foreach (ys[j])
                    if (!seed_written[ys[j] * GRID + xs[i]])
                        send_item(mvn_pkg::CMD_WRITE, xs[i], ys[j], draw_seed());
        end
        send_item(mvn_pkg::CMD_QUERY, px, py, $urandom_range(0, 65535));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (noise_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == mvn_pkg::REG_OCTAVE_COUNT)
            octave_count_q = value[3:0];
        else if (idx == mvn_pkg::REG_OCTAVE_BIAS)
            octave_bias_q = value[15:0];
        cfg_writes++;
    endtask

    task automatic set_octaves(input int count, input int bias);
        drain();
        write_reg(mvn_pkg::REG_OCTAVE_COUNT, count);
        write_reg(mvn_pkg::REG_OCTAVE_BIAS, bias);
    endtask

    task automatic test_extremes();
        query_point(0, 0);
        query_point(255, 255);
        query_point(255, 0);
        query_point(0, 255);
        query_point(128, 127);
        send_item(mvn_pkg::CMD_WRITE, 0, 0, 65535);
        send_item(mvn_pkg::CMD_WRITE, 255, 255, 0);
        query_point(0, 0);
        query_point(255, 255);
        query_point(1, 254);
    endtask

    task automatic test_register_limits();
        int counts[4] = '{0, 1, 9, 15};
        int biases[4] = '{0, 1023, 1024, 65535};
        foreach (counts[i])
        begin
            set_octaves(counts[i], biases[i]);
            query_point(255, 255);
            query_point(85, 170);
        end
        // spare indices must leave both registers alone
        drain();
        write_reg(REG_SPARE_2, 16'h0003);
        write_reg(REG_SPARE_3, 16'hFFFF);
        query_point(170, 85);
        query_point(255, 255);
    endtask

    task automatic test_backpressure();
        set_octaves(mvn_pkg::OCTAVE_COUNT_RESET, mvn_pkg::OCTAVE_BIAS_RESET);
        rx_hold_left = 4000;
        for (int i = 0; i < 10; i++)
            query_point(3 * i, 255 - i);
        drain();
        // sender holds off until everything has come back
        for (int i = 0; i < 3; i++)
            query_point($urandom_range(0, 255), $urandom_range(0, 255));
        drain();
    endtask

    task automatic test_random(input int items);
        int wx, wy;
        for (int ph = 0; ph < 6 && writes_sent + queries_sent < items; ph++)
        begin
            set_octaves($urandom_range(0, 15), (ph == 0) ? 1024 : $urandom_range(0, 65535));
            tx_idle = (ph % 3) != 1;
            rx_idle = (ph % 3) != 2;
            wx = $urandom_range(0, 255);
            wy = $urandom_range(0, 255);
            for (int k = 0; k < 100 && writes_sent + queries_sent < items; k++)
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        send_item(mvn_pkg::CMD_WRITE, $urandom_range(0, 255),
                                  $urandom_range(0, 255), draw_seed());
                    3:
                        query_point($urandom_range(0, 255), $urandom_range(0, 255));
                    default:
                        query_point((wx + $urandom_range(0, 15)) % GRID,
                                    (wy + $urandom_range(0, 15)) % GRID);
                endcase
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_register_limits();
        test_backpressure();
        test_random(600);
        drain();
        $display("Covered %0d seed writes, %0d queries, %0d register writes;",
                 writes_sent, queries_sent, cfg_writes);
        $display("octave count and bias limits, long result hold-off and drained pauses.");
        if (mismatches == 0 && noise_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/mvn_pkg.sv
rtl/mvn_front.sv
rtl/mvn_div.sv
rtl/mvn_back.sv
rtl/multi_octave_value_noise.sv
rtl/mvn_checker.sv
verif/tb_multi_octave_value_noise.sv
